@@ hw/rtl/line_period_correlation_tracker_defines.svh @@
// Assertion macros shared by the line period correlation tracker.
`ifndef LINE_PERIOD_CORRELATION_TRACKER_DEFINES_SVH
`define LINE_PERIOD_CORRELATION_TRACKER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LPCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpct assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define LPCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpct assertion failed");

`endif

@@ hw/rtl/lpct_pkg.sv @@
// ----------------------------------------------------------------------------
// lpct_pkg
// Constants and control types shared by the line period correlation tracker.
// ----------------------------------------------------------------------------
package lpct_pkg;

  localparam int LINE_DEPTH  = 8192;
  localparam int LINE_AW     = 13;
  localparam int LAG_DEPTH   = 1024;
  localparam int LAG_AW      = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int CORR_W      = 54;
  localparam int LEAK_SHIFT  = 20;
  localparam int GAIN_SHIFT  = 10;
  localparam int MAG_SHIFT   = 22;
  localparam int H_W         = 13;
  localparam int MIN_HTOTAL  = 64;
  localparam int MAX_HTOTAL  = 4096;
  localparam int MAX_SPAN    = (LAG_DEPTH - 1) / 2;
  localparam int DIV_STEPS   = 39;
  localparam int DRAIN_LAST  = 4;
  localparam int PEAK_W      = 10;
  localparam int RATE_W      = 32;
  localparam int HTOTAL_RST  = 2200;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              clr;
    logic              prep;
    logic              oread;
    logic              olatch;
    logic              issue;
    logic [LAG_AW-1:0] lag;
    logic              div_init;
    logic              div_step;
    logic              rate;
    logic              emit;
  } lpct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [LAG_AW-1:0] last_lag;
  } lpct_sts_t;

endpackage

@@ hw/rtl/lpct_ram.sv @@
// ----------------------------------------------------------------------------
// lpct_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/lpct_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpct_ctrl
// Sequencer: clearing pass, set-up, lag sweep, pipeline drain, divide, rate update and emit.
// ----------------------------------------------------------------------------
module lpct_ctrl
  import lpct_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_update,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  lpct_sts_t sts,
  output lpct_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PREP, S_OREAD, S_OLATCH, S_SWEEP, S_DRAIN, S_DIVI, S_DIV,
    S_RATE, S_EMIT
  } state_t;

  state_t            state;
  logic [LAG_AW-1:0] cnt;
  logic              emit_ok;

  assign in_ready = (state == S_IDLE);
  assign emit_ok  = (state == S_EMIT) && (!out_valid || out_ready);

  // Commands decoded from the state.
  always_comb begin
    cmd          = '0;
    cmd.lag      = cnt;
    cmd.clr      = (state == S_CLEAR);
    cmd.prep     = (state == S_PREP);
    cmd.oread    = (state == S_OREAD);
    cmd.olatch   = (state == S_OLATCH);
    cmd.issue    = (state == S_SWEEP);
    cmd.div_init = (state == S_DIVI);
    cmd.div_step = (state == S_DIV);
    cmd.rate     = (state == S_RATE);
    cmd.emit     = emit_ok;
  end

  // State, step counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAG_AW'(LAG_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            state <= in_update ? S_PREP : S_EMIT;
          end
        end
        S_PREP:   state <= S_OREAD;
        S_OREAD:  state <= S_OLATCH;
        S_OLATCH: state <= S_SWEEP;
        S_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == sts.last_lag) begin
            cnt   <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAG_AW'(DRAIN_LAST)) begin
            cnt   <= '0;
            state <= S_DIVI;
          end
        end
        S_DIVI: state <= S_DIV;
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAG_AW'(DIV_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_RATE;
          end
        end
        S_RATE: state <= S_EMIT;
        S_EMIT: begin
          if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/lpct_datapath.sv @@
// ----------------------------------------------------------------------------
// lpct_datapath
// Delay line, lag average store, multiply-accumulate pipeline, divider, rate.
// ----------------------------------------------------------------------------
module lpct_datapath
  import lpct_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q,
  input  logic                          cfg_we,
  input  logic [H_W-1:0]                cfg_wdata,
  input  lpct_cmd_t                     cmd,
  output lpct_sts_t                     sts,
  output logic signed [PEAK_W-1:0]      peak_offset,
  output logic signed [RATE_W-1:0]      rate_offset
);

  localparam int SW = 2 * SAMPLE_BITS;
  localparam int PW = 2 * SAMPLE_BITS;

  // Configuration and write side of the delay line.
  logic [H_W-1:0]     htotal;
  logic [LINE_AW-1:0] wp, wp_cur;
  logic [LINE_AW:0]   fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      htotal <= H_W'(HTOTAL_RST);
      wp     <= '0;
      fill   <= '0;
    end else begin
      if (cfg_we) begin
        htotal <= cfg_wdata;
      end
      if (accept) begin
        wp <= wp + 1'b1;
        if (fill != (LINE_AW + 1)'(LINE_DEPTH)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wp_cur <= wp;
    end
  end

  // Effective line length and lag span.
  logic [H_W-1:0]  h_clamp, h_r;
  logic [8:0]      d_r;
  logic [H_W+15:0] d_prod;
  logic [H_W-1:0]  d_raw;

  always_comb begin
    h_clamp = htotal;
    if (htotal < H_W'(MIN_HTOTAL)) h_clamp = H_W'(MIN_HTOTAL);
    if (htotal > H_W'(MAX_HTOTAL)) h_clamp = H_W'(MAX_HTOTAL);
    // Ceiling of h/10 through a reciprocal, exact for these widths.
    d_prod = (H_W + 16)'(h_clamp + H_W'(9)) * (H_W + 16)'(6554);
    d_raw  = d_prod[H_W+15:16];
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      h_r <= h_clamp;
      d_r <= (d_raw > H_W'(MAX_SPAN)) ? 9'(MAX_SPAN) : d_raw[8:0];
    end
  end

  assign sts.last_lag = {d_r, 1'b0};

  // Delay line read address and the never-written check.
  logic [LINE_AW:0]   line_dist;
  logic [LINE_AW-1:0] line_raddr;
  logic [SW-1:0]      line_rdata;
  logic               line_zero;

  always_comb begin
    if (cmd.oread) begin
      line_dist = (LINE_AW + 1)'(h_r) + (LINE_AW + 1)'(d_r);
    end else begin
      line_dist = (LINE_AW + 1)'({d_r, 1'b0}) - (LINE_AW + 1)'(cmd.lag);
    end
    line_raddr = wp_cur - line_dist[LINE_AW-1:0];
  end

  always_ff @(posedge clk) begin
    line_zero <= (line_dist >= fill);
  end

  lpct_ram #(.WIDTH(SW), .DEPTH(LINE_DEPTH)) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata ({sample_q, sample_i}),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  // Delayed sample that every lag is correlated against.
  logic signed [SAMPLE_BITS-1:0] o_i, o_q, x_i, x_q;

  assign x_i = line_zero ? '0 : line_rdata[SAMPLE_BITS-1:0];
  assign x_q = line_zero ? '0 : line_rdata[SW-1:SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (cmd.olatch) begin
      o_i <= x_i;
      o_q <= x_q;
    end
  end

  // Lag average store, real part in the low half.
  logic                  corr_we;
  logic [LAG_AW-1:0]     corr_waddr;
  logic [2*CORR_W-1:0]   corr_wdata, corr_rdata;
  logic                  v1, v2, v3, v4;
  logic [LAG_AW-1:0]     j1, j2, j3, j4;
  logic signed [CORR_W-1:0] cr2, ci2, cr3, ci3;
  logic signed [PW-1:0]  p_ii, p_qq, p_iq, p_qi;
  logic [63:0]           sq_r, sq_i;

  assign corr_we    = cmd.clr || v3;
  assign corr_waddr = cmd.clr ? cmd.lag : j3;
  assign corr_wdata = cmd.clr ? '0 : {ci3, cr3};

  lpct_ram #(.WIDTH(2 * CORR_W), .DEPTH(LAG_DEPTH)) u_corr (
    .clk   (clk),
    .we    (corr_we),
    .waddr (corr_waddr),
    .wdata (corr_wdata),
    .raddr (cmd.lag),
    .rdata (corr_rdata)
  );

  // Leaky update with saturation to the store width.
  function automatic logic signed [CORR_W-1:0] leak_add(
    input logic signed [CORR_W-1:0] c,
    input logic signed [PW:0]       p
  );
    logic signed [CORR_W+1:0] t;
    t = (CORR_W + 2)'(c) - (CORR_W + 2)'(c >>> LEAK_SHIFT) + (CORR_W + 2)'(p);
    if (t > (CORR_W + 2)'(signed'({1'b0, {(CORR_W - 1){1'b1}}}))) begin
      return {1'b0, {(CORR_W - 1){1'b1}}};
    end else if (t < (CORR_W + 2)'(signed'({1'b1, {(CORR_W - 1){1'b0}}}))) begin
      return {1'b1, {(CORR_W - 1){1'b0}}};
    end
    return t[CORR_W-1:0];
  endfunction

  logic signed [PW:0]  pr, pi;
  logic signed [31:0]  ar, ai;
  logic [63:0]         mag;

  assign pr  = (PW + 1)'(p_ii) + (PW + 1)'(p_qq);
  assign pi  = (PW + 1)'(p_iq) - (PW + 1)'(p_qi);
  assign ar  = 32'(cr3 >>> MAG_SHIFT);
  assign ai  = 32'(ci3 >>> MAG_SHIFT);
  assign mag = sq_r + sq_i;

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Products, leak, squared magnitude and the running peak.
  logic [LAG_AW-1:0] best_j;
  logic [63:0]       best_mag;

  always_ff @(posedge clk) begin
    j1   <= cmd.lag;
    j2   <= j1;
    j3   <= j2;
    j4   <= j3;
    p_ii <= o_i * x_i;
    p_qq <= o_q * x_q;
    p_iq <= o_i * x_q;
    p_qi <= o_q * x_i;
    cr2  <= corr_rdata[CORR_W-1:0];
    ci2  <= corr_rdata[2*CORR_W-1:CORR_W];
    cr3  <= leak_add(cr2, pr);
    ci3  <= leak_add(ci2, pi);
    sq_r <= 64'(ar * ar);
    sq_i <= 64'(ai * ai);
    if (v4 && (j4 == '0 || mag > best_mag)) begin
      best_mag <= mag;
      best_j   <= j4;
    end
  end

  // Restoring divider for the target rate, one quotient bit per step.
  logic signed [LAG_AW:0] off;
  logic [DIV_STEPS-1:0]   dvd;
  logic [H_W-1:0]         rem;
  logic [H_W:0]           rem_sh;
  logic                   neg;

  assign off    = signed'({1'b0, best_j}) - signed'((LAG_AW + 1)'(d_r));
  assign rem_sh = {rem, dvd[DIV_STEPS-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg <= off[LAG_AW];
      dvd <= {(off[LAG_AW] ? 9'(-off) : 9'(off)), 30'b0};
      rem <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= (H_W + 1)'(h_r)) begin
        rem <= H_W'(rem_sh - (H_W + 1)'(h_r));
        dvd <= {dvd[DIV_STEPS-2:0], 1'b1};
      end else begin
        rem <= rem_sh[H_W-1:0];
        dvd <= {dvd[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  // Rate smoothing and the held results.
  logic signed [33:0]       target, diff;
  logic signed [34:0]       r_sum;
  logic signed [RATE_W-1:0] rate_rem, r_sat;
  logic signed [PEAK_W-1:0] last_peak;

  always_comb begin
    target = neg ? -signed'({1'b0, dvd[32:0]}) : signed'({1'b0, dvd[32:0]});
    diff   = target - 34'(rate_rem);
    r_sum  = 35'(rate_rem) + 35'(diff >>> GAIN_SHIFT);
    if (r_sum > 35'(signed'({1'b0, {(RATE_W - 1){1'b1}}}))) begin
      r_sat = {1'b0, {(RATE_W - 1){1'b1}}};
    end else if (r_sum < 35'(signed'({1'b1, {(RATE_W - 1){1'b0}}}))) begin
      r_sat = {1'b1, {(RATE_W - 1){1'b0}}};
    end else begin
      r_sat = r_sum[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_rem  <= '0;
      last_peak <= '0;
    end else if (cmd.rate) begin
      rate_rem  <= r_sat;
      last_peak <= off[PEAK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      peak_offset <= last_peak;
      rate_offset <= rate_rem;
    end
  end

endmodule

@@ hw/rtl/line_period_correlation_tracker.sv @@
// ----------------------------------------------------------------------------
// line_period_correlation_tracker
// Tracks the video line period by delayed autocorrelation of I/Q samples.
// ----------------------------------------------------------------------------
// One item is one complex sample; each yields one result item. An item
// without the update flag goes from the accepting cycle straight to the emit
// cycle. An item with the flag passes through the accepting cycle, set-up,
// the lag sweep over 2D+1 lags through the single multiply-accumulate
// pipeline, where D = ceil(htotal/10), the pipeline drain, the divider load,
// 39 divider steps, the rate update and the emit cycle. After reset a
// clearing pass over all 1024 lag entries zeroes the lag averages before
// the first item. A finished result may wait in the output register while
// the next item is taken in.
`include "line_period_correlation_tracker_defines.svh"

module line_period_correlation_tracker
  import lpct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // sample_i [15:0], sample_q [31:16]
  input  logic        s_axis_tuser,  // update_enable
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // peak_offset [9:0], rate_offset [41:10]
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata
);

  lpct_cmd_t                cmd;
  lpct_sts_t                sts;
  logic                     accept;
  logic signed [PEAK_W-1:0] peak_offset;
  logic signed [RATE_W-1:0] rate_offset;

  assign accept = s_axis_tvalid && s_axis_tready;

  lpct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_update (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpct_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .sample_i    (s_axis_tdata[15:0]),
    .sample_q    (s_axis_tdata[31:16]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .sts         (sts),
    .peak_offset (peak_offset),
    .rate_offset (rate_offset)
  );

  assign m_axis_tdata = {6'b0, rate_offset, peak_offset};

  // No new item is taken while the lag sweep runs.
  `LPCT_ASSERT_NOW(a_no_accept_in_sweep, cmd.issue, !s_axis_tready)
  // The sweep never passes the last lag of the span.
  `LPCT_ASSERT_NOW(a_lag_in_span, cmd.issue, cmd.lag <= sts.last_lag)
  // A delivered peak offset lies within the lag span.
  `LPCT_ASSERT_NOW(a_peak_range, m_axis_tvalid,
                   $signed(peak_offset) <= 10'sd410 && $signed(peak_offset) >= -10'sd410)
  // An emit sets the output valid flag; a result is emitted only into a free or draining output register.
  `LPCT_ASSERT_NEXT(a_emit_sets_valid, cmd.emit, m_axis_tvalid)

endmodule
